/* rtl/btok_pkg.sv */
// btok_pkg: shared types, character codes, token kinds and byte classes
// for the byte stream tokenizer. No dependencies.
package btok_pkg;

  // Front queue between classifier and scanner
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Token output queue
  localparam int ODEPTH = 4;
  localparam int OPTR_W = $clog2(ODEPTH);
  localparam int OCNT_W = $clog2(ODEPTH + 1);

  // Output field width of token_length
  localparam int TOKLEN_W = 16;

  // Character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // Token kinds
  localparam logic [4:0] KIND_NUMBER = 5'd0;
  localparam logic [4:0] KIND_LPAREN = 5'd1;
  localparam logic [4:0] KIND_RPAREN = 5'd2;
  localparam logic [4:0] KIND_LBRACK = 5'd3;
  localparam logic [4:0] KIND_RBRACK = 5'd4;
  localparam logic [4:0] KIND_LBRACE = 5'd5;
  localparam logic [4:0] KIND_RBRACE = 5'd6;
  localparam logic [4:0] KIND_DOT    = 5'd7;
  localparam logic [4:0] KIND_COMMA  = 5'd8;
  localparam logic [4:0] KIND_BANG   = 5'd9;
  localparam logic [4:0] KIND_COLON  = 5'd10;
  localparam logic [4:0] KIND_SEMI   = 5'd11;
  localparam logic [4:0] KIND_CHAR   = 5'd12;
  localparam logic [4:0] KIND_STRING = 5'd13;
  localparam logic [4:0] KIND_SPACE  = 5'd14;
  localparam logic [4:0] KIND_END    = 5'd15;
  localparam logic [4:0] KIND_ERROR  = 5'd16;

  // Byte classes
  localparam logic [2:0] CLS_ZERO   = 3'd0;
  localparam logic [2:0] CLS_DIGIT  = 3'd1;
  localparam logic [2:0] CLS_BLANK  = 3'd2;
  localparam logic [2:0] CLS_QUOTE  = 3'd3;
  localparam logic [2:0] CLS_APOS   = 3'd4;
  localparam logic [2:0] CLS_BSLASH = 3'd5;
  localparam logic [2:0] CLS_PUNCT  = 3'd6;
  localparam logic [2:0] CLS_OTHER  = 3'd7;

  // Classified byte
  typedef struct packed {
    logic [2:0] cls;
    logic [4:0] kind;  // punctuation kind, meaningful for CLS_PUNCT
  } entry_t;

  // Front to back word
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } fe_word_t;

  // One token word
  typedef struct packed {
    logic [4:0]          kind;
    logic [31:0]         start;
    logic [TOKLEN_W-1:0] length;
    logic [31:0]         number;
    logic                last;
  } token_t;

  // Single-byte punctuation lookup, KIND_NUMBER means none
  function automatic logic [4:0] punct_kind(input logic [7:0] b);
    logic [4:0] k;
    case (b)
      CH_LPAREN: k = KIND_LPAREN;
      CH_RPAREN: k = KIND_RPAREN;
      CH_LBRACK: k = KIND_LBRACK;
      CH_RBRACK: k = KIND_RBRACK;
      CH_LBRACE: k = KIND_LBRACE;
      CH_RBRACE: k = KIND_RBRACE;
      CH_DOT:    k = KIND_DOT;
      CH_COMMA:  k = KIND_COMMA;
      CH_BANG:   k = KIND_BANG;
      CH_COLON:  k = KIND_COLON;
      CH_SEMI:   k = KIND_SEMI;
      default:   k = KIND_NUMBER;
    endcase
    return k;
  endfunction

  function automatic entry_t classify(input logic [7:0] b);
    entry_t e;
    e.kind = punct_kind(b);
    if (b == CH_NUL)                        e.cls = CLS_ZERO;
    else if (b >= CH_ZERO && b <= CH_NINE)  e.cls = CLS_DIGIT;
    else if (b == CH_SPACE || b == CH_TAB)  e.cls = CLS_BLANK;
    else if (b == CH_QUOTE)                 e.cls = CLS_QUOTE;
    else if (b == CH_APOS)                  e.cls = CLS_APOS;
    else if (b == CH_BSLASH)                e.cls = CLS_BSLASH;
    else if (e.kind != KIND_NUMBER)         e.cls = CLS_PUNCT;
    else                                    e.cls = CLS_OTHER;
    return e;
  endfunction

endpackage

/* rtl/btok_front.sv */
// btok_front: accepts text bytes, classifies them and holds them in a
// short queue for the scanner. Depends on btok_pkg.
module btok_front import btok_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] text_byte,
  input  logic       push,
  output logic       full,
  output fe_word_t   fe,
  input  logic       take
);

  entry_t              q [QDEPTH];
  logic [QPTR_W-1:0]   wp, rp;
  logic [QCNT_W-1:0]   cnt;
  logic                wr, rd;

  assign full = (cnt == QCNT_W'(QDEPTH));
  assign wr   = push && !full;
  assign rd   = take && (cnt != '0);

  // Head word to the scanner
  assign fe.valid = (cnt != '0);
  assign fe.entry = q[rp];

  // Queue storage
  always_ff @(posedge clk) begin
    if (wr) q[wp] <= classify(text_byte);
  end

  // Pointers and fill count; depth is a power of two so pointers wrap
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (wr) wp <= wp + QPTR_W'(1);
      if (rd) rp <= rp + QPTR_W'(1);
      cnt <= cnt + QCNT_W'(wr) - QCNT_W'(rd);
    end
  end

endmodule

/* rtl/btok_back.sv */
// btok_back: scanner state machine and token queue. Takes one classified byte
// per cycle if two slots are free and writes up to two tokens. Depends on btok_pkg.
module btok_back import btok_pkg::*; #(
  parameter int LENGTH_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  fe_word_t    fe,
  output logic        take,
  input  logic        pop,
  output logic        empty,
  output logic [4:0]  token_kind,
  output logic [31:0] token_start,
  output logic [15:0] token_length,
  output logic [31:0] token_number,
  output logic        last_of_run
);

  localparam logic [2:0] MODE_IDLE   = 3'd0;
  localparam logic [2:0] MODE_NUMBER = 3'd1;
  localparam logic [2:0] MODE_SPACE  = 3'd2;
  localparam logic [2:0] MODE_STRING = 3'd3;
  localparam logic [2:0] MODE_CHAR1  = 3'd4;
  localparam logic [2:0] MODE_CHAR2  = 3'd5;

  localparam int OUT_W = (LENGTH_BITS < TOKLEN_W) ? LENGTH_BITS : TOKLEN_W;
  localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

  // Scanner registers
  logic [2:0]             mode, mode_next;
  logic [LENGTH_BITS-1:0] len, len_next;
  logic [31:0]            start, start_next;
  logic [31:0]            off, off_next;
  logic [31:0]            cnt, cnt_next;
  logic                   bsl, bsl_next;

  // Token slots: A closes a pending run, B comes from the idle decode
  logic                   a_vld, b_vld;
  logic [4:0]             a_kind, b_kind;
  logic [31:0]            a_start, b_start;
  logic [LENGTH_BITS-1:0] a_len, b_len, len_up;
  logic                   from_idle, end_seen;
  logic [2:0]             cls;
  token_t                 tok_a, tok_b;

  // Output queue
  token_t                 ob [ODEPTH];
  logic [OPTR_W-1:0]      owp, orp;
  logic [OCNT_W-1:0]      ocnt;
  logic [1:0]             n_wr;
  logic                   rd;

  function automatic logic [TOKLEN_W-1:0] len_out(input logic [LENGTH_BITS-1:0] v);
    return TOKLEN_W'(v[OUT_W-1:0]);
  endfunction

  assign cls    = fe.entry.cls;
  assign len_up = (len == LEN_MAX) ? len : len + LENGTH_BITS'(1);

  // Scanner next state and tokens
  always_comb begin
    mode_next  = mode;
    len_next   = len;
    start_next = start;
    off_next   = off;
    cnt_next   = cnt;
    bsl_next   = bsl;
    a_vld      = 1'b0;
    a_kind     = KIND_ERROR;
    a_start    = start;
    a_len      = len;
    b_vld      = 1'b0;
    b_kind     = KIND_ERROR;
    b_start    = off;
    b_len      = LENGTH_BITS'(1);
    from_idle  = 1'b0;
    end_seen   = 1'b0;

    case (mode)
      MODE_NUMBER, MODE_SPACE: begin
        if ((mode == MODE_NUMBER) ? (cls == CLS_DIGIT) : (cls == CLS_BLANK)) begin
          len_next = len_up;
        end else begin
          a_vld     = 1'b1;
          a_kind    = (mode == MODE_NUMBER) ? KIND_NUMBER : KIND_SPACE;
          from_idle = 1'b1;
        end
      end
      MODE_STRING: begin
        if (cls == CLS_ZERO) begin
          a_vld     = 1'b1;
          from_idle = 1'b1;
        end else begin
          len_next = len_up;
          if (bsl && cls == CLS_QUOTE) begin
            bsl_next = 1'b0;
          end else if (cls == CLS_QUOTE) begin
            bsl_next  = 1'b0;
            a_vld     = 1'b1;
            a_kind    = KIND_STRING;
            a_len     = len_up;
            mode_next = MODE_IDLE;
          end else begin
            bsl_next = (cls == CLS_BSLASH);
          end
        end
      end
      MODE_CHAR1, MODE_CHAR2: begin
        if (cls == CLS_ZERO) begin
          a_vld     = 1'b1;
          from_idle = 1'b1;
        end else if (mode == MODE_CHAR1) begin
          len_next  = len_up;
          mode_next = MODE_CHAR2;
        end else begin
          len_next  = len_up;
          a_vld     = 1'b1;
          a_kind    = (cls == CLS_APOS) ? KIND_CHAR : KIND_ERROR;
          a_len     = len_up;
          mode_next = MODE_IDLE;
        end
      end
      default: begin
        from_idle = 1'b1;
      end
    endcase

    // Decode from idle
    if (from_idle) begin
      mode_next  = MODE_IDLE;
      start_next = off;
      len_next   = LENGTH_BITS'(1);
      case (cls)
        CLS_ZERO: begin
          b_vld    = 1'b1;
          b_kind   = KIND_END;
          b_len    = '0;
          end_seen = 1'b1;
        end
        CLS_DIGIT:  mode_next = MODE_NUMBER;
        CLS_BLANK:  mode_next = MODE_SPACE;
        CLS_QUOTE: begin
          mode_next = MODE_STRING;
          bsl_next  = 1'b0;
        end
        CLS_APOS:   mode_next = MODE_CHAR1;
        CLS_PUNCT: begin
          b_vld  = 1'b1;
          b_kind = fe.entry.kind;
        end
        default: begin
          b_vld  = 1'b1;
          b_kind = KIND_ERROR;
        end
      endcase
    end

    // Counters; end of text restarts everything
    if (end_seen) begin
      mode_next  = MODE_IDLE;
      len_next   = '0;
      start_next = '0;
      off_next   = '0;
      cnt_next   = '0;
      bsl_next   = 1'b0;
    end else begin
      off_next = off + 32'd1;
      cnt_next = cnt + 32'(a_vld) + 32'(b_vld);
    end
  end

  // Token words
  always_comb begin
    tok_a.kind   = a_kind;
    tok_a.start  = a_start;
    tok_a.length = len_out(a_len);
    tok_a.number = cnt + 32'd1;
    tok_a.last   = !b_vld;
    tok_b.kind   = b_kind;
    tok_b.start  = b_start;
    tok_b.length = len_out(b_len);
    tok_b.number = a_vld ? cnt + 32'd2 : cnt + 32'd1;
    tok_b.last   = 1'b1;
  end

  // Take a byte only when two output slots are free
  assign take  = fe.valid && (ocnt <= OCNT_W'(ODEPTH - 2));
  assign n_wr  = take ? (2'(a_vld) + 2'(b_vld)) : 2'd0;
  assign empty = (ocnt == '0);
  assign rd    = pop && !empty;

  // Scanner state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_IDLE;
      len   <= '0;
      start <= '0;
      off   <= '0;
      cnt   <= '0;
      bsl   <= 1'b0;
    end else if (take) begin
      mode  <= mode_next;
      len   <= len_next;
      start <= start_next;
      off   <= off_next;
      cnt   <= cnt_next;
      bsl   <= bsl_next;
    end
  end

  // Output queue storage, tokens written in order
  always_ff @(posedge clk) begin
    if (take) begin
      if (a_vld) ob[owp] <= tok_a;
      if (b_vld) ob[a_vld ? owp + OPTR_W'(1) : owp] <= tok_b;
    end
  end

  // Output queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      owp  <= '0;
      orp  <= '0;
      ocnt <= '0;
    end else begin
      owp  <= owp + OPTR_W'(n_wr);
      if (rd) orp <= orp + OPTR_W'(1);
      ocnt <= ocnt + OCNT_W'(n_wr) - OCNT_W'(rd);
    end
  end

  // Head token on the ports
  assign token_kind   = ob[orp].kind;
  assign token_start  = ob[orp].start;
  assign token_length = ob[orp].length;
  assign token_number = ob[orp].number;
  assign last_of_run  = ob[orp].last;

  // Checks
  a_ocnt_bound: assert property (@(posedge clk) disable iff (rst)
    ocnt <= OCNT_W'(ODEPTH))
    else $error("token queue overfilled");

  a_end_restart: assert property (@(posedge clk) disable iff (rst)
    (take && cls == CLS_ZERO) |=> (mode == MODE_IDLE && off == '0 && cnt == '0))
    else $error("scanner did not restart after end of text");

  a_tok_visible: assert property (@(posedge clk) disable iff (rst)
    (take && (a_vld || b_vld)) |=> !empty)
    else $error("written token not visible");

  a_mode_legal: assert property (@(posedge clk) disable iff (rst)
    mode <= MODE_CHAR2)
    else $error("scanner mode out of range");

endmodule

/* rtl/byte_stream_tokenizer.sv */
// byte_stream_tokenizer: one text byte per cycle in while not full, tokens out
// through a queue. Bytes are registered in the byte queue, tokens in the token queue.
// Throughput: one byte per cycle while two queue slots are free; a byte that closes a run
// and gives a second token needs two result pops, set by the single-read token queue.
// Reset: synchronous active-high rst empties both queues and returns the scanner
// to idle with offset, token count and run length at zero.
module byte_stream_tokenizer import btok_pkg::*; #(
  parameter int LENGTH_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  text_byte,
  input  logic        push,
  output logic        full,
  output logic [4:0]  token_kind,
  output logic [31:0] token_start,
  output logic [15:0] token_length,
  output logic [31:0] token_number,
  output logic        last_of_run,
  output logic        empty,
  input  logic        pop
);

  fe_word_t fe;
  logic     take;

  // Classifier and byte queue
  btok_front u_front (
    .clk       (clk),
    .rst       (rst),
    .text_byte (text_byte),
    .push      (push),
    .full      (full),
    .fe        (fe),
    .take      (take)
  );

  // Scanner and token queue
  btok_back #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .fe           (fe),
    .take         (take),
    .pop          (pop),
    .empty        (empty),
    .token_kind   (token_kind),
    .token_start  (token_start),
    .token_length (token_length),
    .token_number (token_number),
    .last_of_run  (last_of_run)
  );

endmodule

/* tb/byte_stream_tokenizer_checker.sv */
`timescale 1ns / 100ps
// Token checker for byte_stream_tokenizer: watches the byte and token queues,
// predicts every token from the accepted bytes and compares field by field.
// Depends on btok_pkg for character codes, token kinds and token_t.
module byte_stream_tokenizer_checker import btok_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  text_byte,
  input  logic        push,
  input  logic        full,
  input  logic [4:0]  token_kind,
  input  logic [31:0] token_start,
  input  logic [15:0] token_length,
  input  logic [31:0] token_number,
  input  logic        last_of_run,
  input  logic        empty,
  input  logic        pop,
  output int          errors,
  output int          pending
);

  typedef enum logic [2:0] {
    SCAN_IDLE,
    SCAN_NUMBER,
    SCAN_SPACE,
    SCAN_STRING,
    SCAN_CHAR_BODY,
    SCAN_CHAR_CLOSE
  } scan_t;

  localparam logic [TOKLEN_W-1:0] LEN_MAX = '1;

  // Scanner copy
  scan_t               mode;
  logic [TOKLEN_W-1:0] run_len;
  logic [31:0]         run_start;
  logic [31:0]         byte_off;
  logic [31:0]         token_total;
  logic                escaped;

  // Tokens from the byte at hand, then the tokens still owed by the block
  token_t step_tokens [2];
  int     step_count;
  token_t tokens_due [$];
  int     words_seen;

  function automatic logic [4:0] punct_code(input logic [7:0] b);
    case (b)
      CH_LPAREN: return KIND_LPAREN;
      CH_RPAREN: return KIND_RPAREN;
      CH_LBRACK: return KIND_LBRACK;
      CH_RBRACK: return KIND_RBRACK;
      CH_LBRACE: return KIND_LBRACE;
      CH_RBRACE: return KIND_RBRACE;
      CH_DOT:    return KIND_DOT;
      CH_COMMA:  return KIND_COMMA;
      CH_BANG:   return KIND_BANG;
      CH_COLON:  return KIND_COLON;
      CH_SEMI:   return KIND_SEMI;
      default:   return KIND_ERROR;
    endcase
  endfunction

  task automatic clear_scanner();
    mode        = SCAN_IDLE;
    run_len     = '0;
    run_start   = '0;
    byte_off    = '0;
    token_total = '0;
    escaped     = 1'b0;
  endtask

  task automatic add_token(input logic [4:0] kind, input logic [31:0] start,
                           input logic [TOKLEN_W-1:0] len);
    token_t t;
    token_total = token_total + 1;
    t.kind   = kind;
    t.start  = start;
    t.length = len;
    t.number = token_total;
    t.last   = 1'b0;
    step_tokens[step_count] = t;
    step_count++;
  endtask

  task automatic bump_len();
    if (run_len != LEN_MAX) run_len = run_len + TOKLEN_W'(1);
  endtask

  // Advance the scanner by one byte and queue what it emits
  task automatic tokenize_byte(input logic [7:0] b);
    logic [31:0] here;
    logic        restart;
    logic        is_digit;
    logic        is_blank;
    here     = byte_off;
    restart  = 1'b0;
    is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    is_blank = (b == CH_SPACE) || (b == CH_TAB);
    step_count = 0;

    case (mode)
      SCAN_NUMBER, SCAN_SPACE: begin
        if ((mode == SCAN_NUMBER) ? is_digit : is_blank) begin
          bump_len();
        end else begin
          // run closed by this byte, which is then scanned from idle
          add_token((mode == SCAN_NUMBER) ? KIND_NUMBER : KIND_SPACE, run_start, run_len);
          restart = 1'b1;
        end
      end
      SCAN_STRING: begin
        if (b == CH_NUL) begin
          add_token(KIND_ERROR, run_start, run_len);
          restart = 1'b1;
        end else begin
          bump_len();
          if (escaped && b == CH_QUOTE) begin
            escaped = 1'b0;
          end else if (b == CH_QUOTE) begin
            escaped = 1'b0;
            add_token(KIND_STRING, run_start, run_len);
            mode = SCAN_IDLE;
          end else begin
            escaped = (b == CH_BSLASH);
          end
        end
      end
      SCAN_CHAR_BODY, SCAN_CHAR_CLOSE: begin
        if (b == CH_NUL) begin
          add_token(KIND_ERROR, run_start, run_len);
          restart = 1'b1;
        end else if (mode == SCAN_CHAR_BODY) begin
          bump_len();
          mode = SCAN_CHAR_CLOSE;
        end else begin
          bump_len();
          add_token((b == CH_APOS) ? KIND_CHAR : KIND_ERROR, run_start, run_len);
          mode = SCAN_IDLE;
        end
      end
      default: restart = 1'b1;
    endcase

    byte_off = here + 1;
    if (restart) begin
      mode      = SCAN_IDLE;
      run_start = here;
      run_len   = TOKLEN_W'(1);
      if (b == CH_NUL) begin
        // end of text: end token at the zero byte, then counters restart
        add_token(KIND_END, here, '0);
        clear_scanner();
      end else if (is_digit) begin
        mode = SCAN_NUMBER;
      end else if (is_blank) begin
        mode = SCAN_SPACE;
      end else if (b == CH_QUOTE) begin
        mode    = SCAN_STRING;
        escaped = 1'b0;
      end else if (b == CH_APOS) begin
        mode = SCAN_CHAR_BODY;
      end else begin
        add_token(punct_code(b), here, TOKLEN_W'(1));
      end
    end

    if (step_count > 0) step_tokens[step_count-1].last = 1'b1;
    for (int i = 0; i < step_count; i++) tokens_due.push_back(step_tokens[i]);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got, inout logic bad);
    if (want !== got) begin
      $display("%0t: token word %0d %s expected %0d actual %0d",
               $time, words_seen, name, want, got);
      bad = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    token_t want;
    logic   bad;
    if (rst) begin
      clear_scanner();
      tokens_due.delete();
    end else begin
      // compare the popped word against the oldest prediction
      if (pop && !empty) begin
        words_seen++;
        if (tokens_due.size() == 0) begin
          $display("%0t: unexpected token word, expected none, actual kind %0d start %0d",
                   $time, token_kind, token_start);
          errors++;
        end else begin
          want = tokens_due.pop_front();
          bad  = 1'b0;
          check_field("kind", 32'(want.kind), 32'(token_kind), bad);
          check_field("start", want.start, token_start, bad);
          check_field("length", 32'(want.length), 32'(token_length), bad);
          check_field("number", want.number, token_number, bad);
          check_field("last_of_run", 32'(want.last), 32'(last_of_run), bad);
          if (bad) errors++;
        end
      end
      if (push && !full) tokenize_byte(text_byte);
    end
    pending = tokens_due.size();
  end

endmodule

/* tb/byte_stream_tokenizer_tb.sv */
`timescale 1ns / 100ps
// Top of the byte_stream_tokenizer testbench: clock, reset, byte stimulus,
// token pops and the verdict. Needs btok_pkg and byte_stream_tokenizer_checker.
module byte_stream_tokenizer_tb;
  import btok_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_BYTES = 500;

  logic        clk;
  logic        rst       = 1'b1;
  logic [7:0]  text_byte = 8'h00;
  logic        push      = 1'b0;
  logic        pop       = 1'b0;
  logic        full;
  logic        empty;
  logic [4:0]  token_kind;
  logic [31:0] token_start;
  logic [15:0] token_length;
  logic [31:0] token_number;
  logic        last_of_run;

  int send_idle_pct = 23;
  int recv_idle_pct = 62;
  int bytes_sent    = 0;
  int stall_cycles  = 0;
  int failures;
  int pending;

  logic [7:0] punct_bytes [11] = '{CH_LPAREN, CH_RPAREN, CH_LBRACK, CH_RBRACK,
                                   CH_LBRACE, CH_RBRACE, CH_DOT, CH_COMMA,
                                   CH_BANG, CH_COLON, CH_SEMI};

  // Opening text: field extremes, every punctuation byte and the corner cases
  logic [7:0] opening_text [32] = '{
    CH_ZERO, CH_NINE, CH_SPACE, CH_TAB,            // number closed by blank run
    CH_LPAREN,                                     // blank run closed, two tokens
    CH_RPAREN, CH_LBRACK, CH_RBRACK, CH_LBRACE, CH_RBRACE,
    CH_DOT, CH_COMMA, CH_BANG, CH_COLON, CH_SEMI,
    CH_QUOTE, CH_BSLASH, CH_QUOTE, CH_QUOTE,       // string with escaped quote
    CH_APOS, 8'h78, CH_APOS,                       // good char
    CH_APOS, 8'h79, 8'h7A,                         // bad char close
    8'h0A, 8'hFF,                                  // newline and top byte
    CH_QUOTE, 8'h61, CH_NUL,                       // text ends inside a string
    8'h35, CH_NUL                                  // text ends a number run
  };

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  byte_stream_tokenizer uut (
    .clk          (clk),
    .rst          (rst),
    .text_byte    (text_byte),
    .push         (push),
    .full         (full),
    .token_kind   (token_kind),
    .token_start  (token_start),
    .token_length (token_length),
    .token_number (token_number),
    .last_of_run  (last_of_run),
    .empty        (empty),
    .pop          (pop)
  );

  byte_stream_tokenizer_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .text_byte    (text_byte),
    .push         (push),
    .full         (full),
    .token_kind   (token_kind),
    .token_start  (token_start),
    .token_length (token_length),
    .token_number (token_number),
    .last_of_run  (last_of_run),
    .empty        (empty),
    .pop          (pop),
    .errors       (failures),
    .pending      (pending)
  );

  // Token side: random pop stalls
  always @(negedge clk) begin
    pop <= !rst && ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog on cycles where no word moves on either side
  always @(posedge clk) begin
    if (!rst) begin
      if ((push && !full) || (pop && !empty)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Offer one byte, with random gaps first, and hold it until taken
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push      <= 1'b1;
    text_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  function automatic logic [7:0] nonzero_byte();
    return 8'($urandom_range(255, 1));
  endfunction

  // One piece of text: mostly well-formed tokens, some broken or noise
  task automatic send_fragment();
    int         pick;
    int         sel;
    logic [7:0] b;
    pick = $urandom_range(99);
    if (pick < 18) begin
      repeat ($urandom_range(6, 1)) send_byte(CH_ZERO + 8'($urandom_range(9)));
    end else if (pick < 30) begin
      repeat ($urandom_range(4, 1)) send_byte($urandom_range(1) ? CH_SPACE : CH_TAB);
    end else if (pick < 48) begin
      // string body may hold backslash chains and escaped quotes
      send_byte(CH_QUOTE);
      repeat ($urandom_range(8)) begin
        sel = $urandom_range(9);
        if (sel < 2) begin
          send_byte(CH_BSLASH);
        end else if (sel == 2) begin
          send_byte(CH_BSLASH);
          send_byte(CH_QUOTE);
        end else begin
          do b = nonzero_byte(); while (b == CH_QUOTE);
          send_byte(b);
        end
      end
      if ($urandom_range(9) != 0) send_byte(CH_QUOTE);
    end else if (pick < 62) begin
      send_byte(CH_APOS);
      if ($urandom_range(11) == 0) begin
        send_byte(CH_NUL);
      end else begin
        send_byte(nonzero_byte());
        if ($urandom_range(11) == 0) send_byte(CH_NUL);
        else send_byte($urandom_range(3) != 0 ? CH_APOS : nonzero_byte());
      end
    end else if (pick < 82) begin
      send_byte(punct_bytes[$urandom_range(10)]);
    end else if (pick < 94) begin
      send_byte(nonzero_byte());
    end else begin
      send_byte(CH_NUL);
    end
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct);
    int target;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    target = bytes_sent + PHASE_BYTES;
    while (bytes_sent < target) send_fragment();
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (opening_text[i]) send_byte(opening_text[i]);

    run_phase(23, 62);
    run_phase(62, 23);
    run_phase(0, 0);

    // close whatever the last fragment left open
    send_byte(CH_NUL);
    push <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/btok_pkg.sv
rtl/btok_front.sv
rtl/btok_back.sv
rtl/byte_stream_tokenizer.sv
tb/byte_stream_tokenizer_checker.sv
tb/byte_stream_tokenizer_tb.sv
